// ===== design/hsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Humidity sensor frame decoder package
// Shared constants, the frame record type, CRC-8 step and scale division.
// ----------------------------------------------------------------------------
package hsfd_pkg;

  localparam int unsigned FifoDepthDefault = 4;

  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [7:0] CrcPoly = 8'h31;

  // Byte positions within one frame
  localparam logic [2:0] PosTempMsb = 3'd0;
  localparam logic [2:0] PosTempLsb = 3'd1;
  localparam logic [2:0] PosTempCrc = 3'd2;
  localparam logic [2:0] PosHumMsb  = 3'd3;
  localparam logic [2:0] PosHumLsb  = 3'd4;
  localparam logic [2:0] PosHumCrc  = 3'd5;

  // Conversion scales and offsets (hundredths)
  localparam int unsigned ProdW      = 31;
  localparam int unsigned QuotW      = 15;
  localparam logic [14:0] TempScale  = 15'd17500;
  localparam logic [13:0] HumScale   = 14'd12500;
  localparam logic [15:0] TempOffset = 16'd4500;
  localparam logic [14:0] HumOffset  = 15'd600;
  localparam logic [14:0] HumCeilRaw = 15'd10600;
  localparam logic [13:0] HumMax     = 14'd10000;

  typedef struct packed {
    logic [15:0] temp_code;
    logic [15:0] hum_code;
    logic        crc_fail;
  } hsfd_frame_t;

  // One byte of CRC-8, MSB first, no reflection
  function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  // floor(x / 65535) for x < 2^31: x = a*65536 + b, so q = a + [(a + b) >= 65535]
  function automatic logic [QuotW-1:0] div_full_scale(input logic [ProdW-1:0] x);
    logic [QuotW-1:0] a;
    logic [16:0]      s;
    a = x[ProdW-1:16];
    s = {2'b00, a} + {1'b0, x[15:0]};
    return a + QuotW'(s >= 17'd65535);
  endfunction

endpackage

// ===== design/humidity_sensor_frame_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// Humidity sensor frame decoder
// Checks six-byte sensor frames with CRC-8 and converts both words to units.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive rx_byte_i and frame_start_i with
//   push high; the transaction completes on a rising edge with full low.
//   Bytes come in frame order: temperature MSB, LSB, CRC, humidity MSB, LSB,
//   CRC. Raise frame_start_i on a byte to drop any partial frame and take it
//   as the first byte.
//   Output side is a queue read port: while empty is low the oldest result
//   sits on the result ports; pop high on an edge takes it.
//   Throughput: one byte per cycle while full is low, set by the assembler's
//   single register stage; one result per six bytes.
//   Path: after the sixth byte is taken, a result passes the queue slot,
//   the multiply stage, then the divide-and-clamp stage.
//   Stalls: holding pop low fills the converter pipeline and then the frame
//   queue; full rises only while that queue is full.
//   Reset: asynchronous, active low; clears position, queue and pipeline,
//   so the next byte counts as the first of a frame.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_decoder_unit import hsfd_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_start_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [14:0] temperature_centi_o,
  output logic [13:0]        humidity_centi_o,
  output logic [15:0]        temp_code_o,
  output logic [15:0]        hum_code_o,
  output logic               crc_fail_o
);

  logic        byte_take;    // input transaction completes
  logic        frame_push;   // assembler hands over a finished frame
  hsfd_frame_t frame_in;
  logic        q_empty;
  logic        q_pop;
  hsfd_frame_t frame_out;

  // Hold off every byte while the queue has no room for a finished frame
  assign byte_take = push && !full;

  hsfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (byte_take),
    .rx_byte_i    (rx_byte_i),
    .frame_start_i(frame_start_i),
    .frame_valid_o(frame_push),
    .frame_o      (frame_in)
  );

  // Decouple the assembler from the converter
  hsfd_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (frame_push),
    .wr_data_i(frame_in),
    .full_o   (full),
    .rd_i     (q_pop),
    .empty_o  (q_empty),
    .rd_data_o(frame_out)
  );

  // Convert and hold the result until popped
  hsfd_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (!q_empty),
    .in_frame_i         (frame_out),
    .in_take_o          (q_pop),
    .pop_i              (pop),
    .empty_o            (empty),
    .temperature_centi_o(temperature_centi_o),
    .humidity_centi_o   (humidity_centi_o),
    .temp_code_o        (temp_code_o),
    .hum_code_o         (hum_code_o),
    .crc_fail_o         (crc_fail_o)
  );

`ifndef NO_ASSERTIONS
  // A finished frame never meets a full queue
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_push |-> !full) else $error("frame pushed into a full queue");

  // The converter takes a frame only when one is waiting
  a_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("frame taken from an empty queue");

  // Converted humidity stays clamped
  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (humidity_centi_o <= HumMax)) else $error("humidity out of range");
`endif

endmodule

// ===== design/hsfd_front.sv =====
// ----------------------------------------------------------------------------
// Frame assembler
// Tracks the byte position, checks both CRC-8 words and emits one frame record.
// ----------------------------------------------------------------------------
module hsfd_front import hsfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_start_i,
  output logic        frame_valid_o,
  output hsfd_frame_t frame_o
);

  logic [2:0]  pos_q, pos_d, pos_eff;
  logic [7:0]  crc_q, crc_d, crc_base;
  logic [15:0] temp_word_q, temp_word_d;
  logic [7:0]  hum_hi_q, hum_hi_d;
  logic [7:0]  hum_lo_q, hum_lo_d;
  logic        temp_bad_q, temp_bad_d;

  always_comb begin
    pos_eff  = (frame_start_i || (pos_q > PosHumCrc)) ? PosTempMsb : pos_q;
    crc_base = ((pos_eff == PosTempMsb) || (pos_eff == PosHumMsb)) ? CrcInit : crc_q;

    pos_d         = pos_q;
    crc_d         = crc_q;
    temp_word_d   = temp_word_q;
    hum_hi_d      = hum_hi_q;
    hum_lo_d      = hum_lo_q;
    temp_bad_d    = temp_bad_q;
    frame_valid_o = 1'b0;
    frame_o.temp_code = temp_word_q;
    frame_o.hum_code  = {hum_hi_q, hum_lo_q};
    frame_o.crc_fail  = temp_bad_q || (crc_q != rx_byte_i);

    if (take_i) begin
      pos_d = pos_eff + 3'd1;
      unique case (pos_eff)
        PosTempMsb: begin
          crc_d       = crc8_add(crc_base, rx_byte_i);
          temp_word_d = {rx_byte_i, 8'h00};
        end
        PosTempLsb: begin
          crc_d       = crc8_add(crc_base, rx_byte_i);
          temp_word_d = {temp_word_q[15:8], rx_byte_i};
        end
        PosTempCrc: begin
          temp_bad_d = (crc_q != rx_byte_i);
          crc_d      = CrcInit;
        end
        PosHumMsb: begin
          crc_d    = crc8_add(crc_base, rx_byte_i);
          hum_hi_d = rx_byte_i;
        end
        PosHumLsb: begin
          crc_d    = crc8_add(crc_base, rx_byte_i);
          hum_lo_d = rx_byte_i;
        end
        default: begin
          // Last byte: hand the frame over and rewind
          frame_valid_o = 1'b1;
          pos_d         = PosTempMsb;
          crc_d         = CrcInit;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosTempMsb;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q       <= crc_d;
    temp_word_q <= temp_word_d;
    hum_hi_q    <= hum_hi_d;
    hum_lo_q    <= hum_lo_d;
    temp_bad_q  <= temp_bad_d;
  end

endmodule

// ===== design/hsfd_fifo.sv =====
// ----------------------------------------------------------------------------
// Frame record queue
// Short first-in first-out buffer between the assembler and the converter.
// ----------------------------------------------------------------------------
module hsfd_fifo import hsfd_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_i,
  input  hsfd_frame_t wr_data_i,
  output logic        full_o,
  input  logic        rd_i,
  output logic        empty_o,
  output hsfd_frame_t rd_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  hsfd_frame_t     entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    full_o    = (count_q == CntW'(Depth));
    empty_o   = (count_q == '0);
    rd_data_o = entries_q[rd_ptr_q];

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      count_d = count_q + 1'b1;
    end else if (!wr_i && rd_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      entries_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== design/hsfd_back.sv =====
// ----------------------------------------------------------------------------
// Unit converter
// Two-stage stallable pipeline: scale multiply, then divide, offset and humidity clamp.
// ----------------------------------------------------------------------------
module hsfd_back import hsfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  hsfd_frame_t        in_frame_i,
  output logic               in_take_o,
  input  logic               pop_i,
  output logic               empty_o,
  output logic signed [14:0] temperature_centi_o,
  output logic [13:0]        humidity_centi_o,
  output logic [15:0]        temp_code_o,
  output logic [15:0]        hum_code_o,
  output logic               crc_fail_o
);

  // Stage 1: products
  logic              mul_valid_q;
  hsfd_frame_t       mul_frame_q;
  logic [ProdW-1:0]  prod_t_q, prod_h_q;
  // Stage 2: results
  logic              res_valid_q;
  hsfd_frame_t       res_frame_q;
  logic signed [14:0] temp_q, temp_d;
  logic [13:0]       hum_q, hum_d;

  logic              adv_res, adv_mul;
  logic [QuotW-1:0]  quot_t, quot_h;
  logic signed [15:0] temp_full;

  assign adv_res   = !res_valid_q || pop_i;
  assign adv_mul   = !mul_valid_q || adv_res;
  assign in_take_o = in_valid_i && adv_mul;

  always_comb begin
    quot_t    = div_full_scale(prod_t_q);
    quot_h    = div_full_scale(prod_h_q);
    temp_full = $signed({1'b0, quot_t}) - $signed(TempOffset);
    temp_d    = temp_full[14:0];
    if (quot_h < HumOffset) begin
      hum_d = '0;
    end else if (quot_h > HumCeilRaw) begin
      hum_d = HumMax;
    end else begin
      hum_d = 14'(quot_h - HumOffset);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (adv_mul) begin
        mul_valid_q <= in_valid_i;
      end
      if (adv_res) begin
        res_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_mul && in_valid_i) begin
      mul_frame_q <= in_frame_i;
      prod_t_q    <= ProdW'(in_frame_i.temp_code) * ProdW'(TempScale);
      prod_h_q    <= ProdW'(in_frame_i.hum_code) * ProdW'(HumScale);
    end
    if (adv_res && mul_valid_q) begin
      res_frame_q <= mul_frame_q;
      temp_q      <= temp_d;
      hum_q       <= hum_d;
    end
  end

  assign empty_o             = !res_valid_q;
  assign temperature_centi_o = temp_q;
  assign humidity_centi_o    = hum_q;
  assign temp_code_o         = res_frame_q.temp_code;
  assign hum_code_o          = res_frame_q.hum_code;
  assign crc_fail_o          = res_frame_q.crc_fail;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Humidity sensor frame decoder testbench
// Drives six-byte sensor frames, clean, corrupted, truncated and noisy, and
// checks every decoded reading against an in-bench model of the frame
// decoder, with random idling on both queue ports and one long read stall.
// ----------------------------------------------------------------------------
module testbench;
  import hsfd_pkg::*;

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned IdlePercent = 6;

  // One decoded reading as it leaves the block
  typedef struct {
    logic signed [14:0] temp_centi;
    logic [13:0]        hum_centi;
    logic [15:0]        raw_temp;
    logic [15:0]        raw_hum;
    logic               crc_bad;
  } reading_t;

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic [7:0]         rx_byte_i;
  logic               frame_start_i;
  logic               empty;
  logic               pop;
  logic signed [14:0] temperature_centi_o;
  logic [13:0]        humidity_centi_o;
  logic [15:0]        temp_code_o;
  logic [15:0]        hum_code_o;
  logic               crc_fail_o;

  // Model of the decoder's frame state
  logic [2:0]  frame_pos;
  logic [7:0]  word_crc;
  logic [15:0] temp_word;
  logic [7:0]  hum_msb;
  logic [7:0]  hum_lsb;
  logic        temp_crc_bad;

  // Readings predicted but not yet popped, oldest first
  reading_t pending_readings[$];

  int mismatches  = 0;
  int bytes_sent  = 0;
  int cycle_count = 0;
  int hold_cycles = 0;  // reader stall requested by a test, counted down per cycle
  bit calm        = 1'b0;  // suppress random idling on both sides

  humidity_sensor_frame_decoder_unit dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push                (push),
    .full                (full),
    .rx_byte_i           (rx_byte_i),
    .frame_start_i       (frame_start_i),
    .empty               (empty),
    .pop                 (pop),
    .temperature_centi_o (temperature_centi_o),
    .humidity_centi_o    (humidity_centi_o),
    .temp_code_o         (temp_code_o),
    .hum_code_o          (hum_code_o),
    .crc_fail_o          (crc_fail_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // CRC-8, polynomial 0x31, MSB first: shift one data bit in at a time
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[7] ^ data[i];
      crc = {crc[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return crc;
  endfunction

  // Advance the frame model by one accepted byte; queue a reading on the
  // sixth byte of a frame.
  task automatic decode_byte(input logic [7:0] b, input logic start);
    reading_t   r;
    logic [2:0] p;
    longint     t;
    longint     h;
    p = frame_pos;
    // A start marker (or a stray position) restarts the frame at byte 0
    if (start || p > PosHumCrc) begin
      p        = PosTempMsb;
      word_crc = CrcInit;
    end
    frame_pos = p + 3'd1;
    case (p)
      PosTempMsb: begin
        word_crc  = crc8_step(CrcInit, b);
        temp_word = {b, 8'h00};
      end
      PosTempLsb: begin
        word_crc       = crc8_step(word_crc, b);
        temp_word[7:0] = b;
      end
      PosTempCrc: begin
        temp_crc_bad = (word_crc != b);
        word_crc     = CrcInit;
      end
      PosHumMsb: begin
        word_crc = crc8_step(CrcInit, b);
        hum_msb  = b;
      end
      PosHumLsb: begin
        word_crc = crc8_step(word_crc, b);
        hum_lsb  = b;
      end
      default: begin
        // Exact floors: the offsets are whole hundredths
        t = -4500 + (longint'(temp_word) * 17500) / 65535;
        h = -600 + (longint'({hum_msb, hum_lsb}) * 12500) / 65535;
        if (h < 0) h = 0;
        if (h > 10000) h = 10000;
        r.temp_centi = 15'(t);
        r.hum_centi  = 14'(h);
        r.raw_temp   = temp_word;
        r.raw_hum    = {hum_msb, hum_lsb};
        r.crc_bad    = temp_crc_bad || (word_crc != b);
        pending_readings.push_back(r);
        frame_pos = PosTempMsb;
        word_crc  = CrcInit;
      end
    endcase
  endtask

  // Offer one byte from a falling edge and hold it until the write
  // transaction completes; return at the following falling edge.
  task automatic send_byte(input logic [7:0] b, input logic start);
    if (!calm && $urandom_range(99) < IdlePercent) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push          <= 1'b1;
    rx_byte_i     <= b;
    frame_start_i <= start;
    do @(posedge clk_i); while (full);
    decode_byte(b, start);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Send one whole frame; optionally corrupt either check byte
  task automatic send_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                            input bit mark, input bit spoil_t, input bit spoil_h);
    logic [7:0] t_crc;
    logic [7:0] h_crc;
    t_crc = crc8_step(crc8_step(CrcInit, t_raw[15:8]), t_raw[7:0]);
    h_crc = crc8_step(crc8_step(CrcInit, h_raw[15:8]), h_raw[7:0]);
    if (spoil_t) t_crc ^= 8'($urandom_range(1, 255));
    if (spoil_h) h_crc ^= 8'($urandom_range(1, 255));
    send_byte(t_raw[15:8], mark);
    send_byte(t_raw[7:0], 1'b0);
    send_byte(t_crc, 1'b0);
    send_byte(h_raw[15:8], 1'b0);
    send_byte(h_raw[7:0], 1'b0);
    send_byte(h_crc, 1'b0);
  endtask

  // Mostly random words, now and then a full-scale extreme
  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Drop push, wait for every predicted reading, then let the pipeline settle
  task automatic wait_drained();
    push <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Extremes of both words, both clamps, bad check bytes, a frame with no
  // marker straight after reset and after a finished frame, and a marker
  // that cuts a partial frame short.
  task automatic test_directed();
    send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_frame(16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_frame(16'h8000, 16'd3146, 1'b1, 1'b0, 1'b1);
    send_frame(16'h6666, 16'h8000, 1'b0, 1'b1, 1'b1);
    wait_drained();
  endtask

  // Mostly well-formed frames with random content, the rest truncated
  // frames and loose bytes with random markers.
  task automatic test_random();
    int          stop_at;
    int          pick;
    int          cut;
    logic [15:0] t_raw;
    logic [15:0] h_raw;
    stop_at = bytes_sent + 900;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        t_raw = pick_word();
        h_raw = pick_word();
        send_frame(t_raw, h_raw, $urandom_range(9) < 8,
                   $urandom_range(9) == 0, $urandom_range(9) == 0);
      end else if (pick < 90) begin
        cut = $urandom_range(0, 4);
        send_byte(8'($urandom), 1'b1);
        repeat (cut) send_byte(8'($urandom), 1'b0);
      end else begin
        send_byte(8'($urandom), 1'($urandom));
      end
    end
    wait_drained();
  endtask

  // A stretch with no idling at all on either side
  task automatic test_steady();
    calm = 1'b1;
    repeat (20) send_frame(pick_word(), pick_word(), 1'b1, 1'b0, 1'b0);
    wait_drained();
    calm = 1'b0;
  endtask

  // Hold the reader off long enough that the frame queue fills and the
  // write side stalls, while bytes keep coming.
  task automatic test_backpressure();
    calm        = 1'b1;
    hold_cycles = 400;
    repeat (12) send_frame(pick_word(), pick_word(), 1'b1,
                           $urandom_range(3) == 0, 1'b0);
    wait_drained();
    calm = 1'b0;
  endtask

  // Read side: pop at falling edges, idling at random unless stalled or calm
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      pop <= 1'b0;
    end else if (calm) begin
      pop <= 1'b1;
    end else begin
      pop <= ($urandom_range(99) >= IdlePercent);
    end
  end

  // Compare each popped reading with the oldest prediction
  always @(posedge clk_i) begin : check_reading
    reading_t want;
    if (rst_ni === 1'b1 && pop && !empty) begin
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected reading: T=%0d H=%0d rawT=%h rawH=%h crc_fail=%b",
                   temperature_centi_o, humidity_centi_o, temp_code_o,
                   hum_code_o, crc_fail_o);
      end else begin
        want = pending_readings.pop_front();
        if (temperature_centi_o !== want.temp_centi || humidity_centi_o !== want.hum_centi ||
            temp_code_o !== want.raw_temp || hum_code_o !== want.raw_hum ||
            crc_fail_o !== want.crc_bad) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("reading mismatch: exp T=%0d H=%0d rawT=%h rawH=%h crc_fail=%b,",
                     want.temp_centi, want.hum_centi, want.raw_temp, want.raw_hum,
                     want.crc_bad);
            $display("                  got T=%0d H=%0d rawT=%h rawH=%h crc_fail=%b",
                     temperature_centi_o, humidity_centi_o,
                     temp_code_o, hum_code_o, crc_fail_o);
          end
        end
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    push          = 1'b0;
    pop           = 1'b0;
    rx_byte_i     = 8'h00;
    frame_start_i = 1'b0;
    frame_pos     = PosTempMsb;
    word_crc      = CrcInit;
    temp_word     = 16'h0000;
    hum_msb       = 8'h00;
    hum_lsb       = 8'h00;
    temp_crc_bad  = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random();
    test_steady();
    test_backpressure();

    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/hsfd_pkg.sv
design/hsfd_front.sv
design/hsfd_fifo.sv
design/hsfd_back.sv
design/humidity_sensor_frame_decoder_unit.sv
tb/testbench.sv
